/* src/xsie_pkg.sv */
// Shared types and constants for the x86 subset instruction executor.
package xsie_pkg;

  localparam int MEM_WORDS         = 1024;
  localparam int MEM_AW            = $clog2(MEM_WORDS);
  localparam int INSTR_BYTES_DEF   = 64;
  localparam int NUM_REGS_DEF      = 16;
  localparam int REG_IDX_W         = 4;
  localparam int SP_INDEX          = 4;
  localparam logic [63:0] WORD_BYTES = 64'h8;

  typedef enum logic [2:0] {
    OP_MOV_RR = 3'd0,
    OP_ADD_RR = 3'd1,
    OP_CALL   = 3'd2,
    OP_PUSH   = 3'd3,
    OP_MOV_RM = 3'd4,
    OP_MOV_MR = 3'd5,
    OP_POP    = 3'd6,
    OP_RET    = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    MODE_IMM          = 4'd0,
    MODE_REG          = 4'd1,
    MODE_M_IMM        = 4'd2,
    MODE_M_R1         = 4'd3,
    MODE_M_IMM_R1     = 4'd4,
    MODE_M_R1_R2      = 4'd5,
    MODE_M_IMM_R1_R2  = 4'd6,
    MODE_M_R2S        = 4'd7,
    MODE_M_IMM_R2S    = 4'd8,
    MODE_M_R1_R2S     = 4'd9,
    MODE_M_IMM_R1_R2S = 4'd10
  } mode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [3:0]  src_mode;
    logic [63:0] src_imm;
    logic [3:0]  src_base;
    logic [3:0]  src_index;
    logic [3:0]  src_scale;
    logic [3:0]  dst_mode;
    logic [63:0] dst_imm;
    logic [3:0]  dst_base;
    logic [3:0]  dst_index;
    logic [3:0]  dst_scale;
  } cmd_t;

  typedef struct packed {
    logic        reg_write_en;
    logic [3:0]  reg_write_index;
    logic [63:0] reg_write_value;
    logic        mem_write_en;
    logic [63:0] mem_write_addr;
    logic [63:0] mem_write_data;
    logic [63:0] next_pc;
    logic [63:0] stack_pointer;
  } res_t;

  // register file write request: one general write, then the stack pointer
  typedef struct packed {
    logic                 reg_en;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [63:0]          reg_val;
    logic                 sp_en;
    logic [63:0]          sp_val;
  } rf_wr_t;

endpackage

/* src/xsie_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module xsie_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/xsie_agu.sv */
// Operand value / effective address generator.
module xsie_agu (
  input  logic [3:0]  mode,
  input  logic [63:0] imm,
  input  logic [63:0] r1,
  input  logic [63:0] r2,
  input  logic [3:0]  scale,
  output logic [63:0] value
);
  import xsie_pkg::*;

  logic [63:0] scaled;

  assign scaled = r2 * {60'd0, scale};

  always_comb begin
    unique case (mode)
      MODE_IMM:          value = imm;
      MODE_REG:          value = r1;
      MODE_M_IMM:        value = imm;
      MODE_M_R1:         value = r1;
      MODE_M_IMM_R1:     value = imm + r1;
      MODE_M_R1_R2:      value = r1 + r2;
      MODE_M_IMM_R1_R2:  value = imm + r1 + r2;
      MODE_M_R2S:        value = scaled;
      MODE_M_IMM_R2S:    value = imm + scaled;
      MODE_M_R1_R2S:     value = r1 + scaled;
      MODE_M_IMM_R1_R2S: value = imm + r1 + scaled;
      default:           value = '0;
    endcase
  end

endmodule

/* src/xsie_regfile.sv */
// General register file: four read ports, stack pointer tap, one write plus sp write.
module xsie_regfile #(
  parameter int NUM_REGS = xsie_pkg::NUM_REGS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [3:0][xsie_pkg::REG_IDX_W-1:0]       raddr,
  output logic [3:0][63:0]                          rdata,
  output logic [63:0]                               sp,
  input  xsie_pkg::rf_wr_t                          wr
);
  import xsie_pkg::*;

  localparam int RW = $clog2(NUM_REGS);

  logic [63:0] regs [NUM_REGS];
  logic        gen_we;

  // the stack pointer write wins when both target register 4
  assign gen_we = wr.reg_en && !(wr.sp_en && wr.reg_idx == REG_IDX_W'(SP_INDEX));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[i] = regs[RW'(raddr[i])];
    end
  end

  assign sp = regs[RW'(SP_INDEX)];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (gen_we) begin
        regs[RW'(wr.reg_idx)] <= wr.reg_val;
      end
      if (wr.sp_en) begin
        regs[RW'(SP_INDEX)] <= wr.sp_val;
      end
    end
  end

endmodule

/* src/x86_subset_instruction_executor.sv */
// Top level: executes one pre-decoded x86 subset instruction per item.
//
// Channels: cmd carries one decoded instruction (opcode plus source and
// destination operands); res carries one result per instruction with the
// register write-back, the memory write, the new pc and the stack pointer.
// Both use valid/stall: an item moves at a clock edge with valid high and
// stall low.
// Flow: an instruction is held in the execute register until it commits, and
// its result is then registered in the res register. mov rr, add, call,
// push and mov reg-mem run one per cycle while res is not stalled.
// mov mem-reg, pop and ret use the data memory's registered read port: the
// load is issued first and the data is used at commit; cmd stalls meanwhile.
// Reset: registers, pc and the data memory are zeroed. The memory is cleared
// by a pass that writes one word per cycle over all MEM_WORDS (1024) words,
// and cmd is stalled until that pass ends.
// Stall: while res is stalled the result holds; the execute register still
// accepts one more item, which waits there, and then cmd stalls.
module x86_subset_instruction_executor #(
  parameter int INSTR_BYTES = xsie_pkg::INSTR_BYTES_DEF,
  parameter int NUM_REGS    = xsie_pkg::NUM_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  xsie_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output xsie_pkg::res_t res
);
  import xsie_pkg::*;

  cmd_t              q;
  logic              q_valid;
  logic              phase;
  logic              clr_busy;
  logic [MEM_AW-1:0] clr_idx;
  logic [63:0]       pc;

  logic              accept;
  logic              commit;
  logic              needs_read;
  logic [REG_IDX_W-1:0] sreg, dreg;
  logic [3:0][REG_IDX_W-1:0] rf_raddr;
  logic [3:0][63:0]  rf_rdata;
  logic [63:0]       sp;
  logic [63:0]       srcv, dstv;
  logic [63:0]       ram_rdata;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [63:0]       ram_wdata;
  logic [MEM_AW-1:0] rd_word;
  logic [63:0]       seq_pc, sp_dec;
  rf_wr_t            wr;
  res_t              r;
  logic [63:0]       maddr;
  logic [MEM_AW-1:0] mword;

  function automatic logic [REG_IDX_W-1:0] reg_sel(input logic [3:0] idx);
    if (int'(idx) >= NUM_REGS) begin
      return REG_IDX_W'(int'(idx) - NUM_REGS);
    end
    return idx;
  endfunction

  assign sreg = reg_sel(q.src_base);
  assign dreg = reg_sel(q.dst_base);

  assign rf_raddr[0] = sreg;
  assign rf_raddr[1] = reg_sel(q.src_index);
  assign rf_raddr[2] = dreg;
  assign rf_raddr[3] = reg_sel(q.dst_index);

  xsie_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk   (clk),
    .rst   (rst),
    .raddr (rf_raddr),
    .rdata (rf_rdata),
    .sp    (sp),
    .wr    (wr)
  );

  xsie_agu u_agu_src (
    .mode  (q.src_mode),
    .imm   (q.src_imm),
    .r1    (rf_rdata[0]),
    .r2    (rf_rdata[1]),
    .scale (q.src_scale),
    .value (srcv)
  );

  xsie_agu u_agu_dst (
    .mode  (q.dst_mode),
    .imm   (q.dst_imm),
    .r1    (rf_rdata[2]),
    .r2    (rf_rdata[3]),
    .scale (q.dst_scale),
    .value (dstv)
  );

  assign needs_read = (q.opcode == OP_MOV_MR) || (q.opcode == OP_POP) ||
                      (q.opcode == OP_RET);
  assign rd_word    = (q.opcode == OP_MOV_MR) ? srcv[MEM_AW+2:3] : sp[MEM_AW+2:3];

  assign commit    = q_valid && (!needs_read || phase) && !(res_valid && res_stall);
  assign cmd_stall = clr_busy || (q_valid && !commit);
  assign accept    = cmd_valid && !cmd_stall;

  assign seq_pc = pc + 64'(INSTR_BYTES);
  assign sp_dec = sp - WORD_BYTES;

  always_comb begin
    wr    = '0;
    r     = '0;
    maddr = '0;
    r.next_pc = seq_pc;
    unique case (q.opcode)
      OP_MOV_RR: begin
        wr.reg_en  = 1'b1;
        wr.reg_idx = dreg;
        wr.reg_val = rf_rdata[0];
      end
      OP_ADD_RR: begin
        wr.reg_en  = 1'b1;
        wr.reg_idx = dreg;
        wr.reg_val = rf_rdata[2] + rf_rdata[0];
      end
      OP_CALL: begin
        r.mem_write_en   = 1'b1;
        maddr            = sp_dec;
        r.mem_write_data = seq_pc;
        r.next_pc        = srcv;
        wr.sp_en         = 1'b1;
        wr.sp_val        = sp_dec;
      end
      OP_PUSH: begin
        r.mem_write_en   = 1'b1;
        maddr            = sp_dec;
        r.mem_write_data = rf_rdata[0];
        wr.sp_en         = 1'b1;
        wr.sp_val        = sp_dec;
      end
      OP_MOV_RM: begin
        r.mem_write_en   = 1'b1;
        maddr            = dstv;
        r.mem_write_data = rf_rdata[0];
      end
      OP_MOV_MR: begin
        wr.reg_en  = 1'b1;
        wr.reg_idx = dreg;
        wr.reg_val = ram_rdata;
      end
      OP_POP: begin
        wr.reg_en  = 1'b1;
        wr.reg_idx = sreg;
        wr.reg_val = ram_rdata;
        wr.sp_en   = 1'b1;
        wr.sp_val  = ((sreg == REG_IDX_W'(SP_INDEX)) ? ram_rdata : sp) + WORD_BYTES;
      end
      OP_RET: begin
        r.next_pc = ram_rdata;
        wr.sp_en  = 1'b1;
        wr.sp_val = sp + WORD_BYTES;
      end
      default: begin
      end
    endcase
    mword = maddr[MEM_AW+2:3];
    if (r.mem_write_en) begin
      r.mem_write_addr = {{(61-MEM_AW){1'b0}}, mword, 3'b000};
    end
    r.reg_write_en    = wr.reg_en;
    r.reg_write_index = 4'(wr.reg_idx);
    r.reg_write_value = wr.reg_val;
    if (wr.sp_en) begin
      r.stack_pointer = wr.sp_val;
    end else if (wr.reg_en && wr.reg_idx == REG_IDX_W'(SP_INDEX)) begin
      r.stack_pointer = wr.reg_val;
    end else begin
      r.stack_pointer = sp;
    end
    if (!commit) begin
      wr.reg_en = 1'b0;
      wr.sp_en  = 1'b0;
    end
  end

  assign ram_we    = clr_busy || (commit && r.mem_write_en);
  assign ram_waddr = clr_busy ? clr_idx : mword;
  assign ram_wdata = clr_busy ? '0 : r.mem_write_data;

  xsie_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rd_en (q_valid && needs_read && !phase),
    .raddr (rd_word),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      phase     <= 1'b0;
      clr_busy  <= 1'b1;
      clr_idx   <= '0;
      pc        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        q_valid <= 1'b1;
      end else if (commit) begin
        q_valid <= 1'b0;
      end
      if (commit) begin
        phase <= 1'b0;
      end else if (q_valid && needs_read) begin
        phase <= 1'b1;
      end
      if (commit) begin
        pc        <= r.next_pc;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q <= cmd;
    end
    if (commit) begin
      res <= r;
    end
  end

endmodule

/* src/xsie_checker.sv */
// Port-level checker for the executor, bound to the top level.
module xsie_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input xsie_pkg::res_t res
);

  // memory is being cleared right after reset
  a_stall_after_reset: assert property (@(posedge clk) rst |=> cmd_stall && !res_valid)
    else $error("cmd not stalled or res valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  a_reg_idle_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.reg_write_en |->
      res.reg_write_index == 4'd0 && res.reg_write_value == 64'd0)
    else $error("register write fields not zero");

  a_mem_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.mem_write_addr[2:0] == 3'd0 &&
      (res.mem_write_en || (res.mem_write_addr == 64'd0 && res.mem_write_data == 64'd0)))
    else $error("memory write fields malformed");

endmodule

bind x86_subset_instruction_executor xsie_checker u_xsie_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
